// File: sv/pac_pkg.sv
`timescale 1ns / 1ps
// pac_pkg: widths and limits shared by the polygon centroid block.
// No dependencies.
package pac_pkg;

  localparam int MAX_VERTICES = 16;

  localparam int COORD_W = 16;
  localparam int CNT_W   = 6;
  localparam int SUM2_W  = COORD_W + 1;
  localparam int EDGE_W  = 2 * COORD_W + 1;
  localparam int PROD_W  = SUM2_W + EDGE_W;
  localparam int CROSS_W = 38;
  localparam int WSUM_W  = 57;
  localparam int PSUM_W  = 21;
  localparam int DEN_W   = CROSS_W + 2;
  localparam int QUO_W   = COORD_W + 1;
  localparam int STEP_W  = 6;

endpackage

// File: sv/pac_stream_if.sv
`timescale 1ns / 1ps
// pac_stream_if: valid/ready channels for vertices in and centroids out.
// Depends on pac_pkg.
interface pac_vtx_if import pac_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic                      last_vertex;

  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface pac_cent_if import pac_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] centroid_x;
  logic signed [COORD_W-1:0] centroid_y;
  logic                      degenerate;
  logic                      too_many;

  modport source (output valid, centroid_x, centroid_y, degenerate, too_many, input ready);
  modport sink   (input valid, centroid_x, centroid_y, degenerate, too_many, output ready);
endinterface

// File: sv/polygon_area_centroid.sv
`timescale 1ns / 1ps
// polygon_area_centroid: shoelace area centroid of a polygon, one vertex per transaction.
// Depends on pac_pkg and the channel interfaces in pac_stream_if.
//
// Usage:
//   in_ch carries one vertex (Q11.4 x/y) per transaction; last_vertex closes the polygon.
//   out_ch carries one centroid per closed polygon, with degenerate and too_many flags.
//   Vertices past MAX_VERTICES are dropped and the result reports too_many.
// Sequencing:
//   A single 17x33 multiplier and a radix-2 restoring divider are shared under
//   one sequencer; in_ch.ready is high only while the sequencer is idle.
//   Non-final vertex: accept, then the edge update (M1, M2, SUB, WX, WY, ACC), then POST;
//   the first vertex or one past MAX_VERTICES goes from accept straight to POST.
//   Final vertex: the closing edge update, then two 57-step divisions (one bit per cycle)
//   for x and y; past MAX_VERTICES, POST goes straight to EMIT with too_many set.
// Output:
//   The result sits in an output register; the next polygon's vertices are taken
//   while it waits. Only a following result stalls until out_ch.ready drains it.
// Reset:
//   rst_n low (synchronous) clears the sums, vertex count and output valid.
module polygon_area_centroid import pac_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  pac_vtx_if.sink    in_ch,
  pac_cent_if.source out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_M1, S_M2, S_SUB, S_WX, S_WY, S_ACC,
    S_POST, S_FIN, S_LOAD, S_DIV, S_DEND, S_EMIT
  } state_t;

  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_VERTICES);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(WSUM_W - 1);

  state_t state_r;

  logic signed [COORD_W-1:0] first_x_r, first_y_r, prior_x_r, prior_y_r;
  logic signed [COORD_W-1:0] cur_x_r, cur_y_r;
  logic                      last_r, closing_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [CROSS_W-1:0] cross_r;
  logic signed [WSUM_W-1:0]  wsx_r, wsy_r;
  logic signed [PSUM_W-1:0]  psx_r, psy_r;
  logic signed [EDGE_W-1:0]  c_r;
  logic signed [PROD_W-1:0]  prod_r;

  logic signed [DEN_W-1:0]   den3_r;
  logic [DEN_W-1:0]          den_mag_r;
  logic [WSUM_W-1:0]         num_r;
  logic [DEN_W:0]            rem_r;
  logic [QUO_W-1:0]          q_r;
  logic                      ovf_r, neg_r, deg_r, over_r, axis_r;
  logic [STEP_W-1:0]         step_r;
  logic signed [COORD_W-1:0] cx_r, cy_r;

  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_cx_r, out_cy_r;
  logic                      out_deg_r, out_over_r;

  // edge operands
  logic signed [COORD_W-1:0] ex0, ey0, ex1, ey1;
  assign ex0 = prior_x_r;
  assign ey0 = prior_y_r;
  assign ex1 = closing_r ? first_x_r : cur_x_r;
  assign ey1 = closing_r ? first_y_r : cur_y_r;

  // shared multiplier
  logic signed [SUM2_W-1:0] mul_a;
  logic signed [EDGE_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;

  always_comb begin
    unique case (state_r)
      S_M1:    mul_a = {ex0[COORD_W-1], ex0};
      S_M2:    mul_a = {ex1[COORD_W-1], ex1};
      S_WX:    mul_a = {ex0[COORD_W-1], ex0} + {ex1[COORD_W-1], ex1};
      S_WY:    mul_a = {ey0[COORD_W-1], ey0} + {ey1[COORD_W-1], ey1};
      default: mul_a = '0;
    endcase
    unique case (state_r)
      S_M1:    mul_b = {{(EDGE_W-COORD_W){ey1[COORD_W-1]}}, ey1};
      S_M2:    mul_b = {{(EDGE_W-COORD_W){ey0[COORD_W-1]}}, ey0};
      default: mul_b = c_r;
    endcase
    mul_p = mul_a * mul_b;
  end

  // divider operands and step
  logic signed [WSUM_W-1:0] num_sel;
  logic [WSUM_W-1:0]        num_mag;
  logic [DEN_W-1:0]         den_mag;
  logic signed [DEN_W-1:0]  cross3;
  logic [DEN_W:0]           rem_sh;
  logic                     div_ge;

  always_comb begin
    if (deg_r) begin
      num_sel = axis_r ? {{(WSUM_W-PSUM_W){psy_r[PSUM_W-1]}}, psy_r}
                       : {{(WSUM_W-PSUM_W){psx_r[PSUM_W-1]}}, psx_r};
    end else begin
      num_sel = axis_r ? wsy_r : wsx_r;
    end
    num_mag = num_sel[WSUM_W-1] ? WSUM_W'(-num_sel) : WSUM_W'(num_sel);
    den_mag = den3_r[DEN_W-1] ? DEN_W'(-den3_r) : DEN_W'(den3_r);
    cross3  = {{2{cross_r[CROSS_W-1]}}, cross_r}
            + {cross_r[CROSS_W-1], cross_r, 1'b0};
    rem_sh  = {rem_r[DEN_W-1:0], num_r[WSUM_W-1]};
    div_ge  = rem_sh >= {1'b0, den_mag_r};
  end

  // truncated quotient saturated to 16 bits
  logic signed [COORD_W-1:0] sat_q;
  always_comb begin
    if (neg_r) begin
      if (ovf_r || q_r > QUO_W'(32768)) sat_q = {1'b1, {(COORD_W-1){1'b0}}};
      else                              sat_q = COORD_W'(-q_r);
    end else begin
      if (ovf_r || q_r[QUO_W-1] || q_r[COORD_W-1]) sat_q = {1'b0, {(COORD_W-1){1'b1}}};
      else                                         sat_q = q_r[COORD_W-1:0];
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.centroid_x = out_cx_r;
  assign out_ch.centroid_y = out_cy_r;
  assign out_ch.degenerate = out_deg_r;
  assign out_ch.too_many   = out_over_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      cross_r     <= '0;
      wsx_r       <= '0;
      wsy_r       <= '0;
      psx_r       <= '0;
      psy_r       <= '0;
      closing_r   <= 1'b0;
      first_x_r   <= '0;
      first_y_r   <= '0;
      prior_x_r   <= '0;
      prior_y_r   <= '0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_EMIT) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            cur_x_r <= in_ch.vertex_x;
            cur_y_r <= in_ch.vertex_y;
            last_r  <= in_ch.last_vertex;
            if (cnt_r < CNT_MAX) begin
              psx_r <= psx_r + {{(PSUM_W-COORD_W){in_ch.vertex_x[COORD_W-1]}}, in_ch.vertex_x};
              psy_r <= psy_r + {{(PSUM_W-COORD_W){in_ch.vertex_y[COORD_W-1]}}, in_ch.vertex_y};
              cnt_r <= cnt_r + 1'b1;
              if (cnt_r == '0) begin
                first_x_r <= in_ch.vertex_x;
                first_y_r <= in_ch.vertex_y;
                prior_x_r <= in_ch.vertex_x;
                prior_y_r <= in_ch.vertex_y;
                state_r   <= S_POST;
              end else begin
                state_r   <= S_M1;
              end
            end else begin
              cnt_r   <= CNT_MAX + 1'b1;
              state_r <= S_POST;
            end
          end
        end
        S_M1: begin
          prod_r  <= mul_p;
          state_r <= S_M2;
        end
        S_M2: begin
          c_r     <= prod_r[EDGE_W-1:0];
          prod_r  <= mul_p;
          state_r <= S_SUB;
        end
        S_SUB: begin
          c_r     <= c_r - prod_r[EDGE_W-1:0];
          state_r <= S_WX;
        end
        S_WX: begin
          prod_r  <= mul_p;
          cross_r <= cross_r + {{(CROSS_W-EDGE_W){c_r[EDGE_W-1]}}, c_r};
          state_r <= S_WY;
        end
        S_WY: begin
          prod_r  <= mul_p;
          wsx_r   <= wsx_r + {{(WSUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
          state_r <= S_ACC;
        end
        S_ACC: begin
          wsy_r <= wsy_r + {{(WSUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
          if (closing_r) begin
            state_r <= S_FIN;
          end else begin
            prior_x_r <= cur_x_r;
            prior_y_r <= cur_y_r;
            state_r   <= S_POST;
          end
        end
        S_POST: begin
          priority if (!last_r) begin
            state_r <= S_IDLE;
          end else if (cnt_r > CNT_MAX) begin
            over_r  <= 1'b1;
            deg_r   <= 1'b0;
            cx_r    <= '0;
            cy_r    <= '0;
            state_r <= S_EMIT;
          end else begin
            closing_r <= 1'b1;
            state_r   <= S_M1;
          end
        end
        S_FIN: begin
          over_r <= 1'b0;
          axis_r <= 1'b0;
          if (cross_r != '0) begin
            den3_r <= cross3;
            deg_r  <= 1'b0;
          end else begin
            den3_r <= {{(DEN_W-CNT_W){1'b0}}, cnt_r};
            deg_r  <= 1'b1;
          end
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          num_r     <= num_mag;
          den_mag_r <= den_mag;
          neg_r     <= num_sel[WSUM_W-1] ^ den3_r[DEN_W-1];
          rem_r     <= '0;
          q_r       <= '0;
          ovf_r     <= 1'b0;
          step_r    <= '0;
          state_r   <= S_DIV;
        end
        S_DIV: begin
          rem_r  <= div_ge ? rem_sh - {1'b0, den_mag_r} : rem_sh;
          num_r  <= {num_r[WSUM_W-2:0], 1'b0};
          q_r    <= {q_r[QUO_W-2:0], div_ge};
          ovf_r  <= ovf_r | q_r[QUO_W-1];
          step_r <= step_r + 1'b1;
          if (step_r == STEP_LAST) state_r <= S_DEND;
        end
        S_DEND: begin
          if (!axis_r) begin
            cx_r    <= sat_q;
            axis_r  <= 1'b1;
            state_r <= S_LOAD;
          end else begin
            cy_r    <= sat_q;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_cx_r    <= cx_r;
            out_cy_r    <= cy_r;
            out_deg_r   <= deg_r;
            out_over_r  <= over_r;
            cnt_r       <= '0;
            cross_r     <= '0;
            wsx_r       <= '0;
            wsy_r       <= '0;
            psx_r       <= '0;
            psy_r       <= '0;
            closing_r   <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
